FILE: rtl/core/fpr_pkg.sv
// Shared types and constants for the framed packet receiver.
`timescale 1ns / 1ps
package fpr_pkg;

    localparam int MAX_LEN     = 64;  // lengths at or above this are rejected
    localparam int STORE_DEPTH = 64;  // payload memory entries
    localparam int ADDR_W      = 6;   // payload memory address / length width
    localparam int TYPE_BYTES  = 2;   // type field bytes, big-endian
    localparam int DESC_DEPTH  = 2;   // packet descriptor queue depth
    localparam int DPTR_W      = 1;   // descriptor queue pointer width

    // configuration register word index (paddr[2])
    localparam logic CFG_HEADER = 1'b0;
    localparam logic CFG_FOOTER = 1'b1;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_LEN  = 3'd1,
        PH_TYPE = 3'd2,
        PH_DATA = 3'd3,
        PH_CSUM = 3'd4,
        PH_FOOT = 3'd5
    } t_phase;

    // one accepted packet, handed from parser to emitter
    typedef struct packed {
        logic [15:0]       ptype;
        logic [ADDR_W-1:0] plen;
    } t_desc;

    // payload memory write port
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } t_mem_wr;

endpackage

FILE: rtl/core/fpr_front.sv
// Frame parser: header hunt, length/type capture, checksum and footer check.
`timescale 1ns / 1ps
module fpr_front import fpr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [7:0]  i_rx_byte,
    input  logic [7:0]  i_header,
    input  logic [7:0]  i_footer,
    input  logic        i_back_busy,
    input  logic        i_desc_full,
    output t_mem_wr     o_wr,
    output logic        o_desc_push,
    output t_desc       o_desc
);

    t_phase            r_phase, n_phase;
    logic [ADDR_W-1:0] r_len, n_len;
    logic [ADDR_W-1:0] r_cnt, n_cnt;
    logic [15:0]       r_type, n_type;
    logic [7:0]        r_sum, n_sum;
    logic              accept;
    logic [ADDR_W-1:0] cnt_inc;

    // data writes wait until the emitter has drained the memory; footer bytes wait while the descriptor queue is full
    assign o_full  = ((r_phase == PH_DATA) && i_back_busy) ||
                     ((r_phase == PH_FOOT) && i_desc_full);
    assign accept  = i_push && !o_full;
    assign cnt_inc = r_cnt + ADDR_W'(1);

    assign o_desc.ptype = r_type;
    assign o_desc.plen  = r_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_len   <= '0;
            r_cnt   <= '0;
            r_type  <= '0;
            r_sum   <= '0;
        end else begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_cnt   <= n_cnt;
            r_type  <= n_type;
            r_sum   <= n_sum;
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_len       = r_len;
        n_cnt       = r_cnt;
        n_type      = r_type;
        n_sum       = r_sum;
        o_wr.en     = 1'b0;
        o_wr.addr   = r_cnt;
        o_wr.data   = i_rx_byte;
        o_desc_push = 1'b0;
        if (accept) begin
            case (r_phase)
                PH_HUNT: begin
                    if (i_rx_byte == i_header) n_phase = PH_LEN;
                end
                PH_LEN: begin
                    n_len = i_rx_byte[ADDR_W-1:0];
                    if (9'(i_rx_byte) < 9'(MAX_LEN)) begin
                        n_cnt   = ADDR_W'(TYPE_BYTES);
                        n_type  = '0;
                        n_sum   = i_header + i_rx_byte;
                        n_phase = PH_TYPE;
                    end else begin
                        n_phase = PH_HUNT;
                    end
                end
                PH_TYPE: begin
                    n_sum  = r_sum + i_rx_byte;
                    n_type = {r_type[7:0], i_rx_byte};
                    n_cnt  = r_cnt - ADDR_W'(1);
                    if (r_cnt == ADDR_W'(1)) begin
                        n_phase = (r_len != '0) ? PH_DATA : PH_CSUM;
                    end
                end
                PH_DATA: begin
                    n_sum   = r_sum + i_rx_byte;
                    o_wr.en = 1'b1;
                    n_cnt   = cnt_inc;
                    if (cnt_inc == r_len) n_phase = PH_CSUM;
                end
                PH_CSUM: begin
                    n_phase = (i_rx_byte == r_sum) ? PH_FOOT : PH_HUNT;
                end
                PH_FOOT: begin
                    o_desc_push = (i_rx_byte == i_footer);
                    n_phase     = PH_HUNT;
                end
                default: begin
                    n_phase = PH_HUNT;
                end
            endcase
        end
    end

endmodule

FILE: rtl/core/fpr_desc_fifo.sv
// Small queue of accepted packet descriptors between parser and emitter.
`timescale 1ns / 1ps
module fpr_desc_fifo import fpr_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_desc i_desc,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_desc o_desc
);

    localparam int CNT_W = $clog2(DESC_DEPTH + 1);

    t_desc             r_slot [DESC_DEPTH];
    logic [DPTR_W-1:0] r_wp, r_rp;
    logic [CNT_W-1:0]  r_cnt;
    logic              do_push, do_pop;

    assign o_full  = (r_cnt == CNT_W'(DESC_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_desc  = r_slot[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= r_wp + DPTR_W'(1);
            if (do_pop)  r_rp <= r_rp + DPTR_W'(1);
            if (do_push && !do_pop)      r_cnt <= r_cnt + CNT_W'(1);
            else if (do_pop && !do_push) r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_slot[r_wp] <= i_desc;
    end

endmodule

FILE: rtl/core/fpr_back.sv
// Packet emitter: payload memory and one result per cycle, while pop is held, from a descriptor.
`timescale 1ns / 1ps
module fpr_back import fpr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_mem_wr           i_wr,
    input  logic              i_desc_valid,
    input  t_desc             i_desc,
    output logic              o_desc_pop,
    output logic              o_active,
    output logic              o_empty,
    input  logic              i_pop,
    output logic [15:0]       o_packet_type,
    output logic [ADDR_W-1:0] o_packet_length,
    output logic [ADDR_W-1:0] o_byte_position,
    output logic [7:0]        o_payload_byte,
    output logic              o_has_payload,
    output logic              o_last
);

    logic [7:0]        r_mem [STORE_DEPTH];
    logic [7:0]        r_q;
    logic              r_active;
    t_desc             r_cur;
    logic [ADDR_W-1:0] r_k;
    logic              r_valid;
    logic [15:0]       r_type;
    logic [ADDR_W-1:0] r_len, r_pos;
    logic              r_has, r_last;
    logic              adv, item_has, item_last;

    // output slot free or being taken this cycle
    assign adv        = r_active && (!r_valid || i_pop);
    assign o_desc_pop = !r_active && i_desc_valid;
    assign o_active   = r_active;
    assign item_has   = (r_cur.plen != '0);
    assign item_last  = !item_has || ((r_k + ADDR_W'(1)) == r_cur.plen);

    always_ff @(posedge i_clk) begin
        if (i_wr.en) r_mem[i_wr.addr] <= i_wr.data;
    end

    always_ff @(posedge i_clk) begin
        if (adv) r_q <= r_mem[r_k];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_valid  <= 1'b0;
            r_k      <= '0;
        end else begin
            if (o_desc_pop) begin
                r_active <= 1'b1;
                r_k      <= '0;
            end else if (adv) begin
                if (item_last) r_active <= 1'b0;
                else           r_k      <= r_k + ADDR_W'(1);
            end
            if (adv)        r_valid <= 1'b1;
            else if (i_pop) r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_desc_pop) r_cur <= i_desc;
        if (adv) begin
            r_type <= r_cur.ptype;
            r_len  <= r_cur.plen;
            r_pos  <= r_k;
            r_has  <= item_has;
            r_last <= item_last;
        end
    end

    assign o_empty         = !r_valid;
    assign o_packet_type   = r_type;
    assign o_packet_length = r_len;
    assign o_byte_position = r_pos;
    assign o_payload_byte  = r_has ? r_q : 8'h00;
    assign o_has_payload   = r_has;
    assign o_last          = r_last;

endmodule

FILE: rtl/core/framed_packet_receiver.sv
// Top level of the framed packet receiver: config registers, parser, queue, emitter.
`timescale 1ns / 1ps
// Byte-stream deframer. Each push transaction carries one received byte; frames
// are header, length, two type bytes (big-endian), data bytes, an 8-bit wrapping
// checksum over header/length/type/data, and a footer. Lengths of 64 or more, a
// bad checksum or a bad footer drop the frame silently and the parser returns to
// header hunting. A good frame yields one result per data byte (position, byte,
// type, length, last on the final one), or a single result with has_payload low
// for a zero-length frame. Rate: the parser takes one byte per cycle, except that
// full stays high on the first data byte of a frame while the previous packet is
// still being read out of the single-port-write/single-port-read payload memory,
// and on a footer byte while the two-entry descriptor queue is full. The emitter
// delivers one result per cycle while pop is held, after first loading the
// packet's descriptor; an empty packet's single result carries no byte.
// header_byte sits at address 0 and footer_byte at address 4 of the APB port;
// write them only while no frame is in progress and no results are pending.
module framed_packet_receiver import fpr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input queue side
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_rx_byte,
    // result queue side
    output logic        empty,
    input  logic        pop,
    output logic [15:0] o_packet_type,
    output logic [5:0]  o_packet_length,
    output logic [5:0]  o_byte_position,
    output logic [7:0]  o_payload_byte,
    output logic        o_has_payload,
    output logic        o_last,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0] r_header, r_footer;
    logic       cfg_wr;

    t_mem_wr    mem_wr;
    logic       desc_push, desc_full, desc_pop, desc_valid;
    t_desc      desc_in, desc_out;
    logic       back_active, back_busy;

    // ---- configuration registers ----
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header <= 8'hAA;
            r_footer <= 8'h55;
        end else if (cfg_wr) begin
            case (paddr[2])
                CFG_HEADER: r_header <= pwdata[7:0];
                CFG_FOOTER: r_footer <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            CFG_HEADER: prdata = {24'h0, r_header};
            CFG_FOOTER: prdata = {24'h0, r_footer};
            default:    prdata = '0;
        endcase
    end

    // emitter still owns the payload memory while a packet is queued or draining
    assign back_busy = desc_valid || back_active;

    fpr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_rx_byte   (i_rx_byte),
        .i_header    (r_header),
        .i_footer    (r_footer),
        .i_back_busy (back_busy),
        .i_desc_full (desc_full),
        .o_wr        (mem_wr),
        .o_desc_push (desc_push),
        .o_desc      (desc_in)
    );

    fpr_desc_fifo u_desc_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (desc_push),
        .i_desc  (desc_in),
        .o_full  (desc_full),
        .i_pop   (desc_pop),
        .o_valid (desc_valid),
        .o_desc  (desc_out)
    );

    fpr_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_wr            (mem_wr),
        .i_desc_valid    (desc_valid),
        .i_desc          (desc_out),
        .o_desc_pop      (desc_pop),
        .o_active        (back_active),
        .o_empty         (empty),
        .i_pop           (pop),
        .o_packet_type   (o_packet_type),
        .o_packet_length (o_packet_length),
        .o_byte_position (o_byte_position),
        .o_payload_byte  (o_payload_byte),
        .o_has_payload   (o_has_payload),
        .o_last          (o_last)
    );

endmodule

FILE: rtl/core/fpr_checker.sv
// Port-level checks for the framed packet receiver, bound to the top level.
`timescale 1ns / 1ps
module fpr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic        pop,
    input logic [15:0] o_packet_type,
    input logic [5:0]  o_packet_length,
    input logic [5:0]  o_byte_position,
    input logic [7:0]  o_payload_byte,
    input logic        o_has_payload,
    input logic        o_last
);

    // queue comes up empty out of reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> empty)
        else $error("result queue not empty after reset");

    // an empty-packet result is the only one of its packet
    a_empty_pkt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_has_payload) |->
            (o_last && o_packet_length == 6'd0 && o_byte_position == 6'd0 &&
             o_payload_byte == 8'd0))
        else $error("malformed empty-packet result");

    // data results stay inside the packet and last marks the final byte
    a_data_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_has_payload) |->
            (o_byte_position < o_packet_length &&
             o_last == (o_byte_position + 6'd1 == o_packet_length)))
        else $error("data result position or last flag wrong");

    // a waiting result holds until it is taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=>
            (!empty && $stable(o_packet_type) && $stable(o_byte_position) &&
             $stable(o_payload_byte) && $stable(o_last)))
        else $error("stalled result changed");

endmodule

bind framed_packet_receiver fpr_checker u_fpr_checker (.*);

FILE: verif/tb.sv
// Self-checking random testbench for the framed packet receiver.
`timescale 1ns / 1ps
module tb;
    import fpr_pkg::*;

    localparam int         CLK_HALF      = 6;      // 12 ns period
    localparam int         RESET_CYCLES  = 6;
    localparam int         SETTLE_CYCLES = 16;     // parser/emitter drain before a register write
    localparam int         HOLDOFF       = 400;    // long receiver stall, fills the block
    localparam logic [7:0] HEADER_RESET  = 8'd170;
    localparam logic [7:0] FOOTER_RESET  = 8'd85;

    // one result transaction as seen on the output side
    typedef struct packed {
        logic [15:0] ptype;
        logic [5:0]  plen;
        logic [5:0]  pos;
        logic [7:0]  data;
        logic        has_data;
        logic        last;
    } t_pkt_beat;

    // how a generated frame is damaged, if at all
    typedef enum int {
        FR_GOOD,
        FR_BAD_SUM,
        FR_BAD_FOOT,
        FR_TOO_LONG,
        FR_CUT
    } t_frame_fault;

    // Deframer predictor plus the queue of packet bytes it expects to see emitted.
    class deframe_checker;
        logic [7:0]  header_val;
        logic [7:0]  footer_val;
        t_phase      phase;
        logic [5:0]  frame_len;
        logic [5:0]  byte_cnt;
        logic [15:0] type_acc;
        logic [7:0]  csum;
        logic [7:0]  payload_mem [STORE_DEPTH];
        t_pkt_beat   pending_beats [$];
        int          errors;
        int          checked;

        function new();
            header_val = HEADER_RESET;
            footer_val = FOOTER_RESET;
            phase      = PH_HUNT;
            frame_len  = '0;
            byte_cnt   = '0;
            type_acc   = '0;
            csum       = '0;
            errors     = 0;
            checked    = 0;
        endfunction

        function void set_register(logic idx, logic [7:0] val);
            if (idx == CFG_HEADER) begin
                header_val = val;
            end else begin
                footer_val = val;
            end
        endfunction

        // advance the parser by one accepted byte; a good footer queues the packet
        function void note_byte(logic [7:0] b);
            t_pkt_beat  beat;
            logic [5:0] k;
            case (phase)
                PH_HUNT: begin
                    if (b == header_val) phase = PH_LEN;
                end
                PH_LEN: begin
                    frame_len = b[5:0];
                    if (b < 8'(MAX_LEN)) begin
                        byte_cnt = 6'(TYPE_BYTES);
                        type_acc = '0;
                        csum     = header_val + b;
                        phase    = PH_TYPE;
                    end else begin
                        phase = PH_HUNT;
                    end
                end
                PH_TYPE: begin
                    csum     = csum + b;
                    type_acc = {type_acc[7:0], b};
                    byte_cnt = byte_cnt - 6'd1;
                    if (byte_cnt == '0) phase = (frame_len != '0) ? PH_DATA : PH_CSUM;
                end
                PH_DATA: begin
                    csum                  = csum + b;
                    payload_mem[byte_cnt] = b;
                    byte_cnt              = byte_cnt + 6'd1;
                    if (byte_cnt == frame_len) phase = PH_CSUM;
                end
                PH_CSUM: begin
                    phase = (b == csum) ? PH_FOOT : PH_HUNT;
                end
                PH_FOOT: begin
                    if (b == footer_val) begin
                        if (frame_len == '0) begin
                            beat          = '0;
                            beat.ptype    = type_acc;
                            beat.last     = 1'b1;
                            pending_beats.push_back(beat);
                        end else begin
                            for (k = '0; k < frame_len; k++) begin
                                beat.ptype    = type_acc;
                                beat.plen     = frame_len;
                                beat.pos      = k;
                                beat.data     = payload_mem[k];
                                beat.has_data = 1'b1;
                                beat.last     = (k + 6'd1 == frame_len);
                                pending_beats.push_back(beat);
                            end
                        end
                    end
                    phase = PH_HUNT;
                end
                default: phase = PH_HUNT;
            endcase
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] MISMATCH: %s", $time, msg);
            errors++;
        endtask

        task check_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                report_mismatch($sformatf("result %0d, %s: expected %0h, got %0h",
                                          checked, name, want, got));
            end
        endtask

        task check_beat(t_pkt_beat got);
            t_pkt_beat want;
            if (pending_beats.size() == 0) begin
                report_mismatch($sformatf("unexpected result type=%h pos=%0d byte=%h",
                                          got.ptype, got.pos, got.data));
                return;
            end
            want = pending_beats.pop_front();
            check_field("packet_type",   want.ptype,             got.ptype);
            check_field("packet_length", 16'(want.plen),     16'(got.plen));
            check_field("byte_position", 16'(want.pos),      16'(got.pos));
            check_field("payload_byte",  16'(want.data),     16'(got.data));
            check_field("has_payload",   16'(want.has_data), 16'(got.has_data));
            check_field("last",          16'(want.last),     16'(got.last));
            checked++;
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [7:0]  i_rx_byte;
    logic        empty;
    logic        pop;
    logic [15:0] o_packet_type;
    logic [5:0]  o_packet_length;
    logic [5:0]  o_byte_position;
    logic [7:0]  o_payload_byte;
    logic        o_has_payload;
    logic        o_last;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    deframe_checker deframer = new();

    int send_idle_pct;      // chance per cycle that the sender holds off
    int pop_stall_pct;      // chance per cycle that the receiver stalls
    int holdoff_request;    // one-shot long stall, picked up by the result side
    int sent_bytes;

    framed_packet_receiver DUT (.*);

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs; far beyond the slowest legal run.
    initial begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // One byte transaction. push stays high between back-to-back bytes so the
    // step after an accepted byte never lowers and raises it. The predictor
    // is fed right here, at the edge where the byte was taken.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push      <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (full);
        deframer.note_byte(b);
        sent_bytes++;
    endtask

    // Builds a frame against the current header/footer, with an optional defect.
    // A cut frame stops somewhere in the data, so the next frame's bytes land
    // in the wrong fields and the parser has to recover on its own.
    task automatic send_frame(input int len, input logic [15:0] ptype,
                              input t_frame_fault fault);
        logic [7:0] sum;
        logic [7:0] b;
        int         stop;
        int         k;
        send_byte(deframer.header_val);
        send_byte(8'(len));
        if (fault == FR_TOO_LONG) return;
        sum = deframer.header_val + 8'(len);
        send_byte(ptype[15:8]);
        send_byte(ptype[7:0]);
        sum  = sum + ptype[15:8] + ptype[7:0];
        stop = (fault == FR_CUT) ? int'($urandom_range(len)) : len;
        for (k = 0; k < stop; k++) begin
            b   = 8'($urandom());
            sum = sum + b;
            send_byte(b);
        end
        if (fault == FR_CUT) return;
        send_byte((fault == FR_BAD_SUM) ? sum ^ (8'd1 << $urandom_range(7)) : sum);
        send_byte((fault == FR_BAD_FOOT) ? deframer.footer_val + 8'd1 : deframer.footer_val);
    endtask

    // Mostly well-formed frames with short payloads, some damaged frames,
    // oversized lengths, truncations and loose line noise between them.
    task automatic random_traffic(input int budget);
        int           start;
        int           r;
        int           len;
        t_frame_fault fault;
        start = sent_bytes;
        while (sent_bytes - start < budget) begin
            r = $urandom_range(99);
            if (r < 8) begin
                send_byte(8'($urandom()));
                continue;
            end
            r = $urandom_range(99);
            if (r < 70)      fault = FR_GOOD;
            else if (r < 78) fault = FR_BAD_SUM;
            else if (r < 86) fault = FR_BAD_FOOT;
            else if (r < 94) fault = FR_TOO_LONG;
            else             fault = FR_CUT;
            r = $urandom_range(99);
            if (fault == FR_TOO_LONG) len = $urandom_range(255, MAX_LEN);
            else if (r < 15)          len = 0;
            else if (r < 85)          len = $urandom_range(8, 1);
            else if (r < 97)          len = $urandom_range(MAX_LEN - 2, 9);
            else                      len = MAX_LEN - 1;
            send_frame(len, 16'($urandom()), fault);
        end
    endtask

    // Steer the parser back to header hunting without producing a packet,
    // then wait for every expected result and let the pipeline go quiet.
    task automatic quiesce();
        logic [7:0] b;
        while (deframer.phase != PH_HUNT) begin
            case (deframer.phase)
                PH_LEN:  b = 8'hFF;                          // oversized length
                PH_CSUM: b = deframer.csum + 8'd1;           // wrong checksum
                PH_FOOT: b = deframer.footer_val + 8'd1;     // wrong footer
                default: b = 8'($urandom());
            endcase
            send_byte(b);
        end
        push <= 1'b0;
        while (deframer.pending_beats.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One APB transaction: setup, access until pready, then back to idle.
    task automatic apb_transfer(input logic wr, input logic [2:0] addr,
                                input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_reg(input logic idx);
        logic [31:0] rd;
        logic [31:0] want;
        apb_transfer(1'b0, {idx, 2'b00}, 32'd0, rd);
        want = {24'd0, (idx == CFG_HEADER) ? deframer.header_val : deframer.footer_val};
        if (rd !== want) begin
            deframer.report_mismatch($sformatf("register at %0d reads %h, expected %h",
                                               {idx, 2'b00}, rd, want));
        end
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] val);
        logic [31:0] unused;
        apb_transfer(1'b1, {idx, 2'b00}, {24'd0, val}, unused);
        deframer.set_register(idx, val);
        check_reg(idx);
    endtask

    // Result side: checks every popped transaction and drives pop with random
    // stalls; a long hold-off request is counted down here, cycle by cycle.
    initial begin : result_side
        int        hold;
        t_pkt_beat got;
        hold = 0;
        pop <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty) begin
                got.ptype    = o_packet_type;
                got.plen     = o_packet_length;
                got.pos      = o_byte_position;
                got.data     = o_payload_byte;
                got.has_data = o_has_payload;
                got.last     = o_last;
                deframer.check_beat(got);
            end
            if (holdoff_request > 0) begin
                hold            = holdoff_request;
                holdoff_request = 0;
            end
            if (hold > 0) begin
                hold--;
                pop <= 1'b0;
            end else begin
                pop <= i_rst_n && ($urandom_range(99) >= pop_stall_pct);
            end
        end
    end

    initial begin : stimulus
        logic [7:0] shared;
        i_rst_n   <= 1'b0;
        push      <= 1'b0;
        i_rx_byte <= 8'd0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= 3'd0;
        pwdata    <= 32'd0;
        send_idle_pct   = 0;
        pop_stall_pct   = 0;
        holdoff_request = 0;
        sent_bytes      = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values of both registers
        check_reg(CFG_HEADER);
        check_reg(CFG_FOOTER);

        // Directed: noise while hunting, empty packet with all-ones type,
        // length exactly at the limit, one-byte packet, bad checksum, bad
        // footer; random traffic follows the bad footer on the very next byte.
        send_byte(8'h00);
        send_byte(8'hFF);
        send_frame(0, 16'hFFFF, FR_GOOD);
        send_frame(MAX_LEN, 16'h0000, FR_TOO_LONG);
        send_frame(1, 16'h0000, FR_GOOD);
        send_frame(0, 16'h8001, FR_BAD_SUM);
        send_frame(0, 16'h1234, FR_BAD_FOOT);
        random_traffic(10);
        quiesce();

        // extreme register values, sender idles
        write_reg(CFG_HEADER, 8'h00);
        write_reg(CFG_FOOTER, 8'hFF);
        send_idle_pct = 47;
        random_traffic(10);
        quiesce();

        // receiver stalls, including one long hold-off so full has to assert:
        // a short packet parks in the emitter, the longest one then waits on it
        write_reg(CFG_HEADER, 8'hFF);
        write_reg(CFG_FOOTER, 8'h00);
        send_idle_pct   = 0;
        pop_stall_pct   = 47;
        holdoff_request = HOLDOFF;
        random_traffic(16);
        send_frame(1, 16'($urandom()), FR_GOOD);
        send_frame(MAX_LEN - 1, 16'($urandom()), FR_GOOD);
        quiesce();

        // random registers, both sides idle
        write_reg(CFG_HEADER, 8'($urandom()));
        write_reg(CFG_FOOTER, 8'($urandom()));
        send_idle_pct = 36;
        pop_stall_pct = 36;
        random_traffic(10);
        quiesce();

        // header and footer share one value, no idling
        shared = 8'($urandom());
        write_reg(CFG_HEADER, shared);
        write_reg(CFG_FOOTER, shared);
        send_idle_pct = 0;
        pop_stall_pct = 0;
        random_traffic(10);
        quiesce();

        if (deframer.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/core/fpr_pkg.sv
rtl/core/fpr_front.sv
rtl/core/fpr_desc_fifo.sv
rtl/core/fpr_back.sv
rtl/core/framed_packet_receiver.sv
rtl/core/fpr_checker.sv
verif/tb.sv
